[hdl/snp_pkg.sv]
// Shared types, codes and the control store for the six-bit name packer.
// No dependencies; every other file of the block except snp_if imports this package.
`default_nettype none
package snp_pkg;

	localparam int SECTION_BYTES = 22;

	localparam logic [4:0] FIRST_GROUP_IDX = 5'd2;
	localparam logic [4:0] NONCE_IDX       = 5'(SECTION_BYTES - 2);
	localparam logic [7:0] FILL_MASK       = 8'hAA;
	localparam logic [4:0] HDR_TYPE        = 5'd1;

	localparam logic [7:0] ASCII_UP_A  = 8'h41;
	localparam logic [7:0] ASCII_UP_Z  = 8'h5A;
	localparam logic [7:0] ASCII_LO_A  = 8'h61;
	localparam logic [7:0] ASCII_LO_Z  = 8'h7A;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] ASCII_DOT   = 8'h2E;
	localparam logic [7:0] ASCII_USCR  = 8'h5F;

	localparam logic [5:0] CODE_LOWER_BASE = 6'd26;
	localparam logic [5:0] CODE_DIGIT_BASE = 6'd52;
	localparam logic [5:0] CODE_DOT        = 6'd62;
	localparam logic [5:0] CODE_USCR       = 6'd63;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_SHORT    = 2'd2;
	localparam logic [1:0] ST_LONG     = 2'd3;

	localparam logic [3:0] S_WAIT = 4'd0;
	localparam logic [3:0] S_G0   = 4'd1;
	localparam logic [3:0] S_G1   = 4'd2;
	localparam logic [3:0] S_G2   = 4'd3;
	localparam logic [3:0] S_CHK  = 4'd4;
	localparam logic [3:0] S_FILL = 4'd5;
	localparam logic [3:0] S_NLO  = 4'd6;
	localparam logic [3:0] S_NHI  = 4'd7;
	localparam logic [3:0] S_H0   = 4'd8;
	localparam logic [3:0] S_H1   = 4'd9;
	localparam logic [3:0] S_ERR  = 4'd10;

	localparam logic [3:0] V_ZERO = 4'd0;
	localparam logic [3:0] V_GRP0 = 4'd1;
	localparam logic [3:0] V_GRP1 = 4'd2;
	localparam logic [3:0] V_GRP2 = 4'd3;
	localparam logic [3:0] V_FILL = 4'd4;
	localparam logic [3:0] V_NLO  = 4'd5;
	localparam logic [3:0] V_NHI  = 4'd6;
	localparam logic [3:0] V_HDR0 = 4'd7;
	localparam logic [3:0] V_HDR1 = 4'd8;

	localparam logic [1:0] I_REG  = 2'd0;
	localparam logic [1:0] I_ZERO = 2'd1;
	localparam logic [1:0] I_ONE  = 2'd2;

	localparam logic [2:0] C_NEXT     = 3'd0;
	localparam logic [2:0] C_ALWAYS   = 3'd1;
	localparam logic [2:0] C_NOT_FIN  = 3'd2;
	localparam logic [2:0] C_IDX_END  = 3'd3;
	localparam logic [2:0] C_IDX_MORE = 3'd4;

	localparam logic [1:0] D_WAIT  = 2'd0;
	localparam logic [1:0] D_GROUP = 2'd1;
	localparam logic [1:0] D_ERR   = 2'd2;

	typedef struct packed {
		logic       accept;
		logic       emit;
		logic [3:0] vsel;
		logic [1:0] isel;
		logic       inc;
		logic       clr_grp;
		logic       clr_name;
		logic       st_err;
		logic       last;
		logic [2:0] cond;
		logic [3:0] target;
	} ctrl_t;

	typedef struct packed {
		logic       acc;
		logic [1:0] disp;
		logic       can_emit;
		logic       fin;
		logic       idx_end;
		logic       idx_more;
	} flags_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] code;
	} sixbit_t;

	localparam ctrl_t CTRL_NOP = '{1'b0, 1'b0, V_ZERO, I_REG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		C_ALWAYS, S_WAIT};

	function automatic sixbit_t char_to_code(input logic [7:0] ch);
		sixbit_t r;
		r.valid = 1'b1;
		r.code  = 6'd0;
		if (ch >= ASCII_UP_A && ch <= ASCII_UP_Z) begin
			r.code = 6'(ch - ASCII_UP_A);
		end else if (ch >= ASCII_LO_A && ch <= ASCII_LO_Z) begin
			r.code = 6'(ch - ASCII_LO_A) + CODE_LOWER_BASE;
		end else if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
			r.code = 6'(ch - ASCII_ZERO) + CODE_DIGIT_BASE;
		end else if (ch == ASCII_DOT) begin
			r.code = CODE_DOT;
		end else if (ch == ASCII_USCR) begin
			r.code = CODE_USCR;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

	// control store
	function automatic ctrl_t ucode(input logic [3:0] step);
		ctrl_t w;
		w = CTRL_NOP;
		unique case (step)
			S_WAIT: begin
				w.accept = 1'b1;
			end
			S_G0: begin
				w.emit = 1'b1; w.vsel = V_GRP0; w.inc = 1'b1; w.cond = C_NEXT;
			end
			S_G1: begin
				w.emit = 1'b1; w.vsel = V_GRP1; w.inc = 1'b1; w.cond = C_NEXT;
			end
			S_G2: begin
				w.emit = 1'b1; w.vsel = V_GRP2; w.inc = 1'b1; w.clr_grp = 1'b1;
				w.cond = C_NOT_FIN; w.target = S_WAIT;
			end
			S_CHK: begin
				w.cond = C_IDX_END; w.target = S_NLO;
			end
			S_FILL: begin
				w.emit = 1'b1; w.vsel = V_FILL; w.inc = 1'b1;
				w.cond = C_IDX_MORE; w.target = S_FILL;
			end
			S_NLO: begin
				w.emit = 1'b1; w.vsel = V_NLO; w.inc = 1'b1; w.cond = C_NEXT;
			end
			S_NHI: begin
				w.emit = 1'b1; w.vsel = V_NHI; w.cond = C_NEXT;
			end
			S_H0: begin
				w.emit = 1'b1; w.vsel = V_HDR0; w.isel = I_ZERO; w.cond = C_NEXT;
			end
			S_H1: begin
				w.emit = 1'b1; w.vsel = V_HDR1; w.isel = I_ONE; w.last = 1'b1;
				w.clr_name = 1'b1;
			end
			S_ERR: begin
				w.emit = 1'b1; w.isel = I_ZERO; w.st_err = 1'b1; w.last = 1'b1;
				w.clr_name = 1'b1;
			end
			default: begin
				w = CTRL_NOP;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

[hdl/snp_if.sv]
// Valid/ready channel interfaces for name characters in and section bytes out.
// No dependencies.
`default_nettype none
interface snp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  character;
	logic [15:0] nonce;
	logic        last_char;

	modport source (output valid, character, nonce, last_char, input ready);
	modport sink (input valid, character, nonce, last_char, output ready);
endinterface

interface snp_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] byte_index;
	logic [7:0] byte_value;
	logic [1:0] status;
	logic       last;

	modport source (output valid, byte_index, byte_value, status, last, input ready);
	modport sink (input valid, byte_index, byte_value, status, last, output ready);
endinterface
`default_nettype wire

[hdl/snp_useq.sv]
// Step counter and control store of the six-bit name packer.
// Depends on snp_pkg.
`default_nettype none
module snp_useq (
	input  wire             clk,
	input  wire             arst_n,
	input  snp_pkg::flags_t flags,
	output snp_pkg::ctrl_t  ctrl
);
	import snp_pkg::*;

	logic [3:0] step_q;
	logic [3:0] step_d;
	logic [3:0] step_inc;

	assign ctrl     = ucode(step_q);
	assign step_inc = step_q + 4'd1;

	always_comb begin
		step_d = step_q;
		if (ctrl.accept) begin
			if (flags.acc) begin
				unique case (flags.disp)
					D_GROUP: step_d = S_G0;
					D_ERR:   step_d = S_ERR;
					default: step_d = S_WAIT;
				endcase
			end
		end else if (!ctrl.emit || flags.can_emit) begin
			unique case (ctrl.cond)
				C_NEXT:     step_d = step_inc;
				C_ALWAYS:   step_d = ctrl.target;
				C_NOT_FIN:  step_d = flags.fin ? step_inc : ctrl.target;
				C_IDX_END:  step_d = flags.idx_end ? ctrl.target : step_inc;
				C_IDX_MORE: step_d = flags.idx_more ? ctrl.target : step_inc;
				default:    step_d = S_WAIT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule
`default_nettype wire

[hdl/snp_dpath.sv]
// Datapath of the six-bit name packer: code mapping, packing, counters, output register.
// Depends on snp_pkg and snp_if; driven by the control word from snp_useq.
`default_nettype none
module snp_dpath #(
	parameter int MAX_NAME_LEN = 24
) (
	input  wire             clk,
	input  wire             arst_n,
	input  snp_pkg::ctrl_t  ctrl,
	output snp_pkg::flags_t flags,
	snp_in_if.sink          name_ch,
	snp_out_if.source       section_ch,
	input  wire             cfg_wr_en,
	input  wire [5:0]       cfg_wr_data
);
	import snp_pkg::*;

	localparam int CW = $clog2(MAX_NAME_LEN + 2);

	logic [23:0]   grp_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    err_q;
	logic [4:0]    idx_q;
	logic          fin_q;
	logic [15:0]   nonce_q;
	logic [5:0]    colour_q;

	logic          ovld_q;
	logic [4:0]    oidx_q;
	logic [7:0]    oval_q;
	logic [1:0]    ost_q;
	logic          olast_q;

	sixbit_t       cc;
	logic [1:0]    pos;
	logic          in_range;
	logic [CW-1:0] cnt_n;
	logic [1:0]    err_n;
	logic [23:0]   grp_n;
	logic [23:0]   grp_or;
	logic          grp_emit;
	logic [1:0]    disp;
	logic          acc;
	logic          can_emit;
	logic          act;
	logic [4:0]    extra;
	logic [7:0]    val_d;
	logic [4:0]    idx_d;

	assign name_ch.ready = ctrl.accept;
	assign acc           = name_ch.valid && ctrl.accept;
	assign can_emit      = !ovld_q || section_ch.ready;
	assign act           = !ctrl.accept && (!ctrl.emit || can_emit);

	assign cc       = char_to_code(name_ch.character);
	assign pos      = cnt_q[1:0];
	assign in_range = cnt_q < CW'(MAX_NAME_LEN);

	always_comb begin
		grp_or = grp_q;
		case (pos)
			2'd0:    grp_or[5:0]   = grp_q[5:0] | cc.code;
			2'd1:    grp_or[11:6]  = grp_q[11:6] | cc.code;
			2'd2:    grp_or[17:12] = grp_q[17:12] | cc.code;
			default: grp_or[23:18] = grp_q[23:18] | cc.code;
		endcase
	end

	always_comb begin
		err_n    = err_q;
		grp_n    = grp_q;
		grp_emit = 1'b0;
		if (in_range) begin
			cnt_n = cnt_q + CW'(1);
			if (!cc.valid && err_q == ST_OK) begin
				err_n = ST_BAD_CHAR;
			end
			if (err_n == ST_OK) begin
				grp_n    = grp_or;
				grp_emit = (pos == 2'd3) && !name_ch.last_char;
			end
		end else begin
			cnt_n = CW'(MAX_NAME_LEN + 1);
			err_n = ST_LONG;
		end
		if (name_ch.last_char && cnt_n < CW'(2)) begin
			err_n = ST_SHORT;
		end
		if (grp_emit) begin
			disp = D_GROUP;
		end else if (name_ch.last_char) begin
			disp = (err_n != ST_OK) ? D_ERR : D_GROUP;
		end else begin
			disp = D_WAIT;
		end
	end

	assign flags.acc      = acc;
	assign flags.disp     = disp;
	assign flags.can_emit = can_emit;
	assign flags.fin      = fin_q;
	assign flags.idx_end  = idx_q == NONCE_IDX;
	assign flags.idx_more = (idx_q + 5'd1) != NONCE_IDX;

	assign extra = 5'(cnt_q) - 5'd2;

	always_comb begin
		unique case (ctrl.vsel)
			V_GRP0:  val_d = grp_q[7:0];
			V_GRP1:  val_d = grp_q[15:8];
			V_GRP2:  val_d = grp_q[23:16];
			V_FILL:  val_d = FILL_MASK ^ {3'b000, idx_q};
			V_NLO:   val_d = nonce_q[7:0];
			V_NHI:   val_d = nonce_q[15:8];
			V_HDR0:  val_d = {colour_q[2:0], HDR_TYPE};
			V_HDR1:  val_d = {extra, colour_q[5:3]};
			default: val_d = 8'h00;
		endcase
		unique case (ctrl.isel)
			I_ZERO:  idx_d = 5'd0;
			I_ONE:   idx_d = 5'd1;
			default: idx_d = idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q    <= '0;
			cnt_q    <= '0;
			err_q    <= ST_OK;
			idx_q    <= FIRST_GROUP_IDX;
			fin_q    <= 1'b0;
			colour_q <= '0;
			ovld_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				colour_q <= cfg_wr_data;
			end
			if (acc) begin
				grp_q <= grp_n;
				cnt_q <= cnt_n;
				err_q <= err_n;
				fin_q <= name_ch.last_char;
			end else if (act) begin
				if (ctrl.inc) begin
					idx_q <= idx_q + 5'd1;
				end
				if (ctrl.clr_grp) begin
					grp_q <= '0;
				end
				if (ctrl.clr_name) begin
					grp_q <= '0;
					cnt_q <= '0;
					err_q <= ST_OK;
					idx_q <= FIRST_GROUP_IDX;
					fin_q <= 1'b0;
				end
			end
			if (act && ctrl.emit) begin
				ovld_q <= 1'b1;
			end else if (section_ch.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			nonce_q <= name_ch.nonce;
		end
		if (act && ctrl.emit) begin
			oidx_q  <= idx_d;
			oval_q  <= val_d;
			ost_q   <= ctrl.st_err ? err_q : ST_OK;
			olast_q <= ctrl.last;
		end
	end

	assign section_ch.valid      = ovld_q;
	assign section_ch.byte_index = oidx_q;
	assign section_ch.byte_value = oval_q;
	assign section_ch.status     = ost_q;
	assign section_ch.last       = olast_q;

endmodule
`default_nettype wire

[hdl/six_bit_name_packer.sv]
// Six-bit name packer: one character per transfer in, 22 section bytes or one error out.
// An ordinary character is only packed; a fourth character adds three group bytes.
// The final character starts a burst of one byte per cycle, up to 22 bytes with a check
// step for filler among them; an error gives a single result. The control store's step
// counter sequences the burst, and a full output register stalls it.
// arst_n clears the step counter, packing state and colour register at once.
`default_nettype none
module six_bit_name_packer #(
	parameter int MAX_NAME_LEN = 24
) (
	input  wire       clk,
	input  wire       arst_n,
	snp_in_if.sink    name_ch,
	snp_out_if.source section_ch,
	input  wire       cfg_wr_en,
	input  wire [5:0] cfg_wr_data
);
	import snp_pkg::*;

	ctrl_t  ctrl;
	flags_t flags;

	snp_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	snp_dpath #(
		.MAX_NAME_LEN (MAX_NAME_LEN)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.flags       (flags),
		.name_ch     (name_ch),
		.section_ch  (section_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

endmodule
`default_nettype wire

[hdl/snp_checker.sv]
// Port-level assertions for the six-bit name packer and the bind that attaches them.
// Depends on snp_pkg, six_bit_name_packer and the channel interfaces.
`default_nettype none
module snp_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       in_last_char,
	input wire       out_valid,
	input wire       out_ready,
	input wire [4:0] out_index,
	input wire [7:0] out_value,
	input wire [1:0] out_status,
	input wire       out_last
);
	import snp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable(out_index) && $stable(out_value) && $stable(out_status) && $stable(out_last))
		else $error("result changed while stalled");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_OK |-> out_last && out_index == 5'd0 && out_value == 8'd0)
		else $error("error result malformed");

	a_last_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last && out_status == ST_OK |-> out_index == 5'd1)
		else $error("final ok result is not header byte one");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last_char |=> !in_ready)
		else $error("input taken during final burst");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_index <= 5'd21)
		else $error("byte index out of range");

endmodule

bind six_bit_name_packer snp_checker u_snp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (name_ch.valid),
	.in_ready     (name_ch.ready),
	.in_last_char (name_ch.last_char),
	.out_valid    (section_ch.valid),
	.out_ready    (section_ch.ready),
	.out_index    (section_ch.byte_index),
	.out_value    (section_ch.byte_value),
	.out_status   (section_ch.status),
	.out_last     (section_ch.last)
);
`default_nettype wire

[bench/six_bit_name_packer_test.sv]
// Self-checking bench for six_bit_name_packer: drives names over the character channel
// and predicts every section byte or error result it must produce.
// Depends on snp_pkg (codes and constants) and the snp_in_if / snp_out_if channels.
module six_bit_name_packer_test;
	import snp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_CHARS = 310;

	typedef struct packed {
		logic [4:0] idx;
		logic [7:0] val;
		logic [1:0] status;
		logic       last;
	} section_byte_t;

	class section_tracker;
		localparam int MAX_LEN = 24;

		section_byte_t pending_bytes[$];
		logic [23:0]   group_bytes;
		logic [4:0]    char_count;
		logic [1:0]    name_error;
		logic [5:0]    colour;
		int            failures;
		int            bytes_checked;
		int            names_closed;
		int            status_seen[4];

		function new();
			clear_name();
			colour = 6'd0;
			failures = 0;
			bytes_checked = 0;
			names_closed = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void clear_name();
			group_bytes = 24'd0;
			char_count = 5'd0;
			name_error = ST_OK;
		endfunction

		function bit char_code(input logic [7:0] ch, output logic [5:0] code);
			code = 6'd0;
			if (ch >= ASCII_UP_A && ch <= ASCII_UP_Z) begin
				code = 6'(ch - ASCII_UP_A);
			end else if (ch >= ASCII_LO_A && ch <= ASCII_LO_Z) begin
				code = 6'(ch - ASCII_LO_A) + CODE_LOWER_BASE;
			end else if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
				code = 6'(ch - ASCII_ZERO) + CODE_DIGIT_BASE;
			end else if (ch == ASCII_DOT) begin
				code = CODE_DOT;
			end else if (ch == ASCII_USCR) begin
				code = CODE_USCR;
			end else begin
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void push_byte(input logic [4:0] idx, input logic [7:0] val,
			input logic [1:0] status, input logic last);
			section_byte_t b;
			b.idx = idx;
			b.val = val;
			b.status = status;
			b.last = last;
			pending_bytes.push_back(b);
		endfunction

		function void push_group(input logic [4:0] start);
			push_byte(start, group_bytes[7:0], ST_OK, 1'b0);
			push_byte(start + 5'd1, group_bytes[15:8], ST_OK, 1'b0);
			push_byte(start + 5'd2, group_bytes[23:16], ST_OK, 1'b0);
		endfunction

		function void note_char(input logic [7:0] ch, input logic [15:0] nonce,
			input logic last_char);
			logic [5:0] code;
			bit         ok;
			logic [4:0] pos;
			logic [4:0] start;
			ok = char_code(ch, code);
			if (char_count < 5'(MAX_LEN)) begin
				pos = char_count;
				char_count = char_count + 5'd1;
				if (!ok && name_error == ST_OK) name_error = ST_BAD_CHAR;
				if (name_error == ST_OK) begin
					group_bytes = group_bytes | (24'(code) << (6 * pos[1:0]));
					if (pos[1:0] == 2'd3 && !last_char) begin
						push_group(FIRST_GROUP_IDX + 5'(3 * pos[4:2]));
						group_bytes = 24'd0;
					end
				end
			end else begin
				char_count = 5'(MAX_LEN + 1);
				name_error = ST_LONG;
			end
			if (last_char) begin
				if (char_count < 5'd2) name_error = ST_SHORT;
				if (name_error != ST_OK) begin
					push_byte(5'd0, 8'd0, name_error, 1'b1);
				end else begin
					start = FIRST_GROUP_IDX + 5'(3 * ((char_count - 5'd1) >> 2));
					push_group(start);
					for (int i = start + 3; i < NONCE_IDX; i++)
						push_byte(5'(i), FILL_MASK ^ 8'(i), ST_OK, 1'b0);
					push_byte(NONCE_IDX, nonce[7:0], ST_OK, 1'b0);
					push_byte(NONCE_IDX + 5'd1, nonce[15:8], ST_OK, 1'b0);
					push_byte(5'd0, {colour[2:0], HDR_TYPE}, ST_OK, 1'b0);
					push_byte(5'd1, {5'(char_count - 5'd2), colour[5:3]}, ST_OK, 1'b1);
				end
				names_closed++;
				clear_name();
			end
		endfunction

		function void check_byte(input section_byte_t got);
			section_byte_t want;
			bytes_checked++;
			status_seen[got.status]++;
			if (pending_bytes.size() == 0) begin
				failures++;
				$display("%0t: unexpected byte: idx %0d val %02h status %0d last %0d",
					$time, got.idx, got.val, got.status, got.last);
				return;
			end
			want = pending_bytes.pop_front();
			if (got !== want) begin
				failures++;
				$display("%0t: mismatch: expected idx %0d val %02h status %0d last %0d",
					$time, want.idx, want.val, want.status, want.last);
				$display("%0t:           actual idx %0d val %02h status %0d last %0d",
					$time, got.idx, got.val, got.status, got.last);
			end
		endfunction

		function int pending();
			return pending_bytes.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [5:0] cfg_wr_data;
	bit         calm;
	int         idle_cycles;
	int         chars_sent;

	section_tracker sb = new();

	snp_in_if  in_ch();
	snp_out_if out_ch();

	six_bit_name_packer dut (
		.clk(clk),
		.arst_n(arst_n),
		.name_ch(in_ch),
		.section_ch(out_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ch.ready <= calm || ($urandom_range(99) >= 28);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_byte({out_ch.byte_index, out_ch.byte_value, out_ch.status, out_ch.last});
			if (in_ch.valid && in_ch.ready)
				sb.note_char(in_ch.character, in_ch.nonce, in_ch.last_char);
			if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("simulation failed");
		$finish;
	end

	function automatic logic [7:0] pick_name_char();
		case ($urandom_range(3))
			0: begin
				return ASCII_UP_A + 8'($urandom_range(25));
			end
			1: begin
				return ASCII_LO_A + 8'($urandom_range(25));
			end
			2: begin
				return ASCII_ZERO + 8'($urandom_range(9));
			end
			default: begin
				return $urandom_range(1) ? ASCII_DOT : ASCII_USCR;
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_bad_char();
		logic [7:0] c;
		logic [5:0] code;
		do c = 8'($urandom_range(255)); while (sb.char_code(c, code));
		return c;
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic [15:0] nonce,
		input logic last_char);
		while (!calm && $urandom_range(99) < 28) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.character <= ch;
		in_ch.nonce <= nonce;
		in_ch.last_char <= last_char;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic hold_off();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic set_colour(input logic [5:0] colour);
		hold_off();
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= colour;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.colour = colour;
	endtask

	task automatic send_word(input string s, input logic [15:0] nonce, input int hold_at);
		for (int i = 0; i < s.len(); i++) begin
			if (i == hold_at) hold_off();
			send_char(s[i], (i == s.len() - 1) ? nonce : 16'($urandom),
				i == s.len() - 1);
		end
	endtask

	task automatic send_name(input int len, input int bad_at, input logic [15:0] nonce);
		logic [7:0] ch;
		for (int i = 0; i < len; i++) begin
			ch = (i == bad_at) ? pick_bad_char() : pick_name_char();
			if (!calm && $urandom_range(99) < 2) hold_off();
			send_char(ch, (i == len - 1) ? nonce : 16'($urandom), i == len - 1);
		end
	endtask

	initial begin
		logic [5:0] phase_colour[4];
		int         start_chars;
		int         len;
		int         bad_at;
		int         pick;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 6'd0;
		in_ch.valid = 1'b0;
		in_ch.character = 8'd0;
		in_ch.nonce = 16'd0;
		in_ch.last_char = 1'b0;
		out_ch.ready = 1'b0;
		calm = 1'b0;
		idle_cycles = 0;
		chars_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_colour(6'h3f);
		send_word("AZaz09._", 16'hffff, 4);
		send_char("z", 16'h0000, 1'b1);
		send_char("b", 16'h1234, 1'b0);
		send_char(8'hff, 16'hffff, 1'b0);
		send_char("c", 16'h0000, 1'b1);
		send_char(8'h00, 16'h0000, 1'b1);
		send_word("Ab3_.", 16'h0000, -1);
		send_word("q9", 16'h5a3c, -1);

		phase_colour[0] = 6'h00;
		phase_colour[1] = 6'($urandom);
		phase_colour[2] = 6'h2a;
		phase_colour[3] = 6'($urandom);
		start_chars = chars_sent;
		for (int phase = 0; phase < 4; phase++) begin
			set_colour(phase_colour[phase]);
			calm = (phase == 1);
			while (chars_sent - start_chars < RANDOM_CHARS * (phase + 1) / 4) begin
				pick = $urandom_range(99);
				bad_at = -1;
				if (pick < 78) begin
					len = ($urandom_range(7) == 0) ? 24 : $urandom_range(2, 16);
				end else if (pick < 88) begin
					len = $urandom_range(2, 12);
					bad_at = $urandom_range(len - 1);
				end else if (pick < 93) begin
					len = $urandom_range(25, 27);
					if ($urandom_range(1)) bad_at = $urandom_range(len - 1);
				end else begin
					len = 1;
					if ($urandom_range(1)) bad_at = 0;
				end
				send_name(len, bad_at, 16'($urandom));
			end
		end
		calm = 1'b0;

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d names, %0d characters, %0d result bytes over five colours",
			sb.names_closed, chars_sent, sb.bytes_checked);
		$display("error results: %0d bad character, %0d too short, %0d too long",
			sb.status_seen[ST_BAD_CHAR], sb.status_seen[ST_SHORT], sb.status_seen[ST_LONG]);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

[sim.f]
hdl/snp_pkg.sv
hdl/snp_if.sv
hdl/snp_useq.sv
hdl/snp_dpath.sv
hdl/six_bit_name_packer.sv
hdl/snp_checker.sv
bench/six_bit_name_packer_test.sv
